/* src/sows_pkg.sv */
// Shared constants and types for the sparse offset window slicer.
package sows_pkg;

  localparam int unsigned MAX_RANGES_DEF   = 16;
  localparam int unsigned OFFSET_DEPTH_DEF = 1024;
  localparam int unsigned MAX_LIMIT_DEF    = 63;

  localparam int unsigned ROW_W   = 32;
  localparam int unsigned LIM_W   = 6;
  localparam int unsigned OUT_W   = 33;
  localparam int unsigned SKIP_W  = 11;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned WIDE_W  = 34;
  localparam int unsigned ADJ_W   = 36;

  localparam logic [SKIP_W-1:0] SKIP_SAT = {SKIP_W{1'b1}};

  typedef enum logic [1:0] {
    OP_APPEND_RANGE  = 2'd0,
    OP_APPEND_OFFSET = 2'd1,
    OP_CLEAR         = 2'd2,
    OP_QUERY         = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_RANGE_FULL = 3'd2,
    ST_STORE_FULL = 3'd3,
    ST_NO_RANGE   = 3'd4
  } status_t;

endpackage

/* src/sows_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sows_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* src/sparse_offset_window_slicer.sv */
// Top level: range table, offset store and the query sequencer.
//
//  channel | direction | handshake          | contents
//  in_     | input     | in_valid/in_stall   | op, range, offset and query fields
//  out_    | output    | out_valid/out_stall | status, offsets, summary, last
//
// Appends and clears produce a single result transaction.
// A query tests ranges up to and including the first cover, passes over ranges that end
// before the query start, and walks each remaining range one stored position at a time
// (read, then check), paced by the single offset store read port and the shared compare
// unit; out_stall holds emitted transactions. Reset empties both tables at once.
// in_stall is high from acceptance until the last result transaction is taken.
module sparse_offset_window_slicer
  import sows_pkg::*;
#(
  parameter int unsigned MAX_RANGES   = MAX_RANGES_DEF,
  parameter int unsigned OFFSET_DEPTH = OFFSET_DEPTH_DEF,
  parameter int unsigned MAX_LIMIT    = MAX_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [ROW_W-1:0]  in_range_start_row,
  input  logic [ROW_W-1:0]  in_range_row_count,
  input  logic [ROW_W-1:0]  in_offset_position,
  input  logic [ROW_W-1:0]  in_query_start_row,
  input  logic [ROW_W-1:0]  in_skip_rows,
  input  logic [LIM_W-1:0]  in_limit_rows,
  input  logic [ROW_W-1:0]  in_frame_base,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic              out_is_summary,
  output logic [OUT_W-1:0]  out_offset_out,
  output logic [SKIP_W-1:0] out_skipped_count,
  output logic [LIM_W-1:0]  out_read_rows,
  output logic              out_last
);

  localparam int unsigned RW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned RCW = $clog2(MAX_RANGES + 1);
  localparam int unsigned OW  = $clog2(OFFSET_DEPTH);
  localparam int unsigned OCW = $clog2(OFFSET_DEPTH + 1);
  localparam logic [RCW-1:0]   RANGES_FULL = RCW'(MAX_RANGES);
  localparam logic [OCW-1:0]   STORE_FULL  = OCW'(OFFSET_DEPTH);
  localparam logic [LIM_W-1:0] LIM_CAP     = LIM_W'(MAX_LIMIT);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_RANGE = 6'b000100,
    S_RD    = 6'b001000,
    S_CHK   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // range table and fill counters
  logic [ROW_W-1:0] start_tab_r [MAX_RANGES];
  logic [ROW_W-1:0] rows_tab_r  [MAX_RANGES];
  logic [OCW-1:0]   first_tab_r [MAX_RANGES];
  logic [OCW-1:0]   count_tab_r [MAX_RANGES];
  logic [RCW-1:0]   ranges_used_r;
  logic [OCW-1:0]   offsets_used_r;
  logic [OCW-1:0]   open_count_r;

  // query context
  logic [ROW_W-1:0]  qs_r;
  logic [WIDE_W-1:0] prod_lo_r, win_end_r;
  logic [ROW_W-1:0]  base_r;
  logic [LIM_W-1:0]  lim_r;
  logic [SKIP_W-1:0] skipped_r;
  logic [LIM_W-1:0]  n_r;
  logic [RCW-1:0]    i_r;
  logic [OCW-1:0]    k_r, cnt_r, idx_r;
  logic [WIDE_W-1:0] sk_lo_r, sk_hi_r, pr_lo_r, pr_hi_r;
  logic [ADJ_W-1:0]  adj_r;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_sum_r;
  logic [OUT_W-1:0]  out_off_r;
  logic [SKIP_W-1:0] out_skip_r;
  logic [LIM_W-1:0]  out_rd_r;
  logic              out_last_r;

  logic              in_acc, out_acc, ram_we;
  logic [ROW_W-1:0]  ram_rdata;
  logic [WIDE_W-1:0] s_w, e_w, qs_w, p_w;
  logic [WIDE_W-1:0] sk_hi_t, pr_hi_t, lo_t, plo_w, wend_w;
  logic              in_skip, in_prod;
  logic [LIM_W-1:0]  lim_cap;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ram_we   = in_acc && (op_t'(in_op) == OP_APPEND_OFFSET) &&
                    (ranges_used_r != '0) && (offsets_used_r != STORE_FULL);

  sows_ram #(.WIDTH(ROW_W), .DEPTH(OFFSET_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (offsets_used_r[OW-1:0]),
    .wdata (in_offset_position),
    .raddr (idx_r[OW-1:0]),
    .rdata (ram_rdata)
  );

  // shared compare unit over the currently indexed range
  assign s_w     = WIDE_W'(start_tab_r[i_r[RW-1:0]]);
  assign e_w     = s_w + WIDE_W'(rows_tab_r[i_r[RW-1:0]]);
  assign qs_w    = WIDE_W'(qs_r);
  assign lo_t    = (prod_lo_r < e_w) ? prod_lo_r : e_w;
  assign sk_hi_t = (lo_t > s_w) ? lo_t - s_w : '0;
  assign pr_hi_t = ((win_end_r < e_w ? win_end_r : e_w) > s_w) ?
                   (win_end_r < e_w ? win_end_r : e_w) - s_w : '0;
  assign p_w     = WIDE_W'(ram_rdata);
  assign in_skip = (sk_hi_r > sk_lo_r) && (p_w >= sk_lo_r) && (p_w < sk_hi_r);
  assign in_prod = (pr_hi_r > pr_lo_r) && (p_w >= pr_lo_r) && (p_w < pr_hi_r) &&
                   (n_r < LIM_CAP);
  assign lim_cap = (in_limit_rows > LIM_CAP) ? LIM_CAP : in_limit_rows;
  assign plo_w   = WIDE_W'(in_query_start_row) + WIDE_W'(in_skip_rows);
  assign wend_w  = plo_w + WIDE_W'(lim_cap);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (op_t'(in_op) == OP_QUERY) ? S_FIND : S_EMIT;
        end
      end
      S_FIND: begin
        if (i_r >= ranges_used_r) begin
          state_nxt = S_EMIT;
        end else if (s_w <= qs_w && qs_w < e_w) begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (i_r >= ranges_used_r || s_w >= win_end_r) begin
          state_nxt = S_EMIT;
        end else if (e_w > qs_w) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = (k_r == cnt_r) ? S_RANGE : S_CHK;
      S_CHK: state_nxt = in_prod ? S_EMIT : S_RD;
      S_EMIT: begin
        if (out_acc) begin
          state_nxt = out_last_r ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ranges_used_r  <= '0;
      offsets_used_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      priority if (in_acc) begin
        out_valid_r <= (op_t'(in_op) != OP_QUERY);
        unique case (op_t'(in_op))
          OP_APPEND_RANGE: begin
            if (ranges_used_r != RANGES_FULL) begin
              ranges_used_r <= ranges_used_r + 1'b1;
            end
          end
          OP_APPEND_OFFSET: begin
            if (ram_we) begin
              offsets_used_r <= offsets_used_r + 1'b1;
            end
          end
          OP_CLEAR: begin
            ranges_used_r  <= '0;
            offsets_used_r <= '0;
          end
          OP_QUERY: ;
          default: ;
        endcase
      end else if (state_r == S_FIND && i_r >= ranges_used_r) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_RANGE &&
                   (i_r >= ranges_used_r || s_w >= win_end_r)) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_CHK && in_prod) begin
        out_valid_r <= 1'b1;
      end else begin
      end
    end
  end

  // table contents, query context and output payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_sum_r  <= 1'b1;
          out_off_r  <= '0;
          out_skip_r <= '0;
          out_rd_r   <= '0;
          out_last_r <= 1'b1;
          unique case (op_t'(in_op))
            OP_APPEND_RANGE: begin
              if (ranges_used_r == RANGES_FULL) begin
                out_status_r <= ST_RANGE_FULL;
              end else begin
                out_status_r <= ST_OK;
                start_tab_r[ranges_used_r[RW-1:0]] <= in_range_start_row;
                rows_tab_r[ranges_used_r[RW-1:0]]  <= in_range_row_count;
                first_tab_r[ranges_used_r[RW-1:0]] <= offsets_used_r;
                count_tab_r[ranges_used_r[RW-1:0]] <= '0;
                open_count_r <= '0;
              end
            end
            OP_APPEND_OFFSET: begin
              if (ranges_used_r == '0) begin
                out_status_r <= ST_NO_RANGE;
              end else if (offsets_used_r == STORE_FULL) begin
                out_status_r <= ST_STORE_FULL;
              end else begin
                out_status_r <= ST_OK;
                count_tab_r[RW'(ranges_used_r - 1'b1)] <= open_count_r + 1'b1;
                open_count_r <= open_count_r + 1'b1;
              end
            end
            OP_CLEAR: begin
              out_status_r <= ST_OK;
            end
            OP_QUERY: begin
              out_status_r <= ST_OK;
              qs_r      <= in_query_start_row;
              base_r    <= in_frame_base;
              lim_r     <= lim_cap;
              prod_lo_r <= plo_w;
              win_end_r <= wend_w;
              skipped_r <= '0;
              n_r       <= '0;
              i_r       <= '0;
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (i_r >= ranges_used_r) begin
          out_status_r <= ST_NOT_FOUND;
          out_sum_r    <= 1'b1;
          out_off_r    <= '0;
          out_skip_r   <= '0;
          out_rd_r     <= '0;
          out_last_r   <= 1'b1;
        end else if (!(s_w <= qs_w && qs_w < e_w)) begin
          i_r <= i_r + 1'b1;
        end
      end
      S_RANGE: begin
        if (i_r >= ranges_used_r || s_w >= win_end_r) begin
          out_status_r <= ST_OK;
          out_sum_r    <= 1'b1;
          out_off_r    <= '0;
          out_skip_r   <= skipped_r;
          out_rd_r     <= lim_r;
          out_last_r   <= 1'b1;
        end else if (e_w <= qs_w) begin
          i_r <= i_r + 1'b1;
        end else begin
          sk_lo_r <= ((qs_w > s_w) ? qs_w : s_w) - s_w;
          sk_hi_r <= sk_hi_t;
          pr_lo_r <= ((prod_lo_r > s_w) ? prod_lo_r : s_w) - s_w;
          pr_hi_r <= pr_hi_t;
          adj_r   <= ADJ_W'(s_w) + ADJ_W'(base_r) - ADJ_W'(prod_lo_r);
          k_r     <= '0;
          cnt_r   <= count_tab_r[i_r[RW-1:0]];
          idx_r   <= first_tab_r[i_r[RW-1:0]];
        end
      end
      S_RD: begin
        if (k_r == cnt_r) begin
          i_r <= i_r + 1'b1;
        end
      end
      S_CHK: begin
        k_r   <= k_r + 1'b1;
        idx_r <= idx_r + 1'b1;
        if (in_skip && skipped_r != SKIP_SAT) begin
          skipped_r <= skipped_r + 1'b1;
        end
        if (in_prod) begin
          n_r          <= n_r + 1'b1;
          out_status_r <= ST_OK;
          out_sum_r    <= 1'b0;
          out_off_r    <= OUT_W'(ADJ_W'(p_w) + adj_r);
          out_skip_r   <= '0;
          out_rd_r     <= '0;
          out_last_r   <= 1'b0;
        end
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_summary    = out_sum_r;
  assign out_offset_out    = out_off_r;
  assign out_skipped_count = out_skip_r;
  assign out_read_rows     = out_rd_r;
  assign out_last          = out_last_r;

  // a result is only offered while the sequencer waits on it
  a_valid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT)) else $error("result outside emit state");

  // input is taken only when idle
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE)) else $error("accept did not leave idle");

  // fill counters never pass their capacity
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (ranges_used_r <= RANGES_FULL) && (offsets_used_r <= STORE_FULL))
    else $error("fill counter overflow");

  // emitted offsets never exceed the cap
  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && in_prod) |=> (n_r <= LIM_CAP))
    else $error("emission count above cap");

endmodule
